// ===== rtl/signed_binary_to_decimal_text_defines.svh =====
// Assertion macros used by the block's top-level RTL.
`ifndef SIGNED_BINARY_TO_DECIMAL_TEXT_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_TEXT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while in reset.
`define S2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define S2D_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define S2D_ASSERT(lbl, prop, msg)
`define S2D_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/s2d_pkg.sv =====
package s2d_pkg;

  localparam int ValueW    = 64;
  localparam int DigitW    = 4;
  // 2^63 has 19 decimal digits
  localparam int NumDigits = 19;
  localparam int CntW      = $clog2(ValueW);

  localparam logic [7:0]        AsciiZero   = 8'd48;
  localparam logic [7:0]        AsciiMinus  = 8'd45;
  localparam logic [7:0]        AsciiNine   = 8'd57;
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  typedef enum logic [1:0] {
    CellHold,
    CellClear,
    CellDabble,
    CellShift
  } cell_mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

endpackage

// ===== rtl/signed_binary_to_decimal_text.sv =====
// Signed 64-bit integer to decimal ASCII text.
// A word is taken on value_i at a clock edge where start_i is high and
// busy_o is low. The block then emits the text one character per strobe on
// char_valid_o, text_char_o carrying the ASCII code and last_char_o marking
// the final character. A leading '-' marks negative values, leading zeros
// are dropped and zero gives a single '0'.
// The magnitude is shifted MSB first into a row of 19 BCD digit cells, one
// bit per cycle, each cell doing its own add-3 correction. The row is then
// shifted out one digit per cycle from the top cell, leading zero digits
// passing without a strobe. The minus sign is registered during the first
// conversion step, before any digit; a new word is not taken while one is
// in work, and the next start is taken in the cycle of the last strobe.
// busy_o stays high from the accepting edge until the last character is
// registered. Reset returns the block to idle with no strobe pending. The
// receiver cannot stall: every strobe lasts exactly one cycle.
`include "signed_binary_to_decimal_text_defines.svh"

module signed_binary_to_decimal_text (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [s2d_pkg::ValueW-1:0] value_i,
  output logic                        busy_o,
  output logic                        char_valid_o,
  output logic [7:0]                  text_char_o,
  output logic                        last_char_o
);
  import s2d_pkg::*;

  state_e              state_q, state_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                started_q, started_d;
  logic                strobe_q, strobe_d;
  logic [7:0]          char_q, char_d;
  logic                last_q, last_d;
  cell_mode_e          cell_mode;
  logic                accept;
  logic                conv_done;
  logic                emit_last;

  logic [DigitW-1:0]   digit [NumDigits];
  logic                carry [NumDigits];

  assign accept    = start_i && (state_q == StIdle);
  assign conv_done = (cnt_q == CntW'(ValueW - 1));
  assign emit_last = (cnt_q == CntW'(NumDigits - 1));

  for (genvar i = 0; i < NumDigits; i++) begin : g_cells
    logic              bit_in;
    logic [DigitW-1:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = mag_q[ValueW-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    s2d_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (cell_mode),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .bit_o   (carry[i]),
      .digit_o (digit[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StConv;
      StConv: if (conv_done) state_d = StEmit;
      StEmit: if (emit_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_mode = CellHold;
    mag_d     = mag_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cell_mode = CellClear;
          neg_d     = value_i[ValueW-1];
          mag_d     = value_i[ValueW-1] ? ~value_i + 1'b1 : value_i;
          cnt_d     = '0;
          started_d = 1'b0;
        end
      end
      StConv: begin
        cell_mode = CellDabble;
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        cnt_d     = conv_done ? '0 : cnt_q + 1'b1;
        if (cnt_q == '0 && neg_q) begin
          strobe_d = 1'b1;
          char_d   = AsciiMinus;
        end
      end
      StEmit: begin
        cell_mode = CellShift;
        cnt_d     = cnt_q + 1'b1;
        if (started_q || digit[NumDigits-1] != '0 || emit_last) begin
          strobe_d  = 1'b1;
          started_d = 1'b1;
          char_d    = AsciiZero + 8'(digit[NumDigits-1]);
          last_d    = emit_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    char_q <= char_d;
  end

  assign busy_o       = (state_q != StIdle);
  assign char_valid_o = strobe_q;
  assign text_char_o  = char_q;
  assign last_char_o  = last_q;

  `S2D_ASSERT(a_strobe_from_work, char_valid_o |-> $past(state_q != StIdle), "stray strobe")
  `S2D_ASSERT(a_last_has_strobe, last_char_o |-> char_valid_o, "last word without strobe")
  `S2D_ASSERT(a_last_frees, (char_valid_o && last_char_o) |-> !busy_o, "busy after last word")
  `S2D_ASSERT(a_char_code, char_valid_o |-> (text_char_o == AsciiMinus ||
    (text_char_o >= AsciiZero && text_char_o <= AsciiNine)), "bad character code")
  `S2D_ASSERT_NEVER(a_minus_not_last, char_valid_o && last_char_o && text_char_o == AsciiMinus, "minus flagged last")

endmodule

// ===== rtl/s2d_cell.sv =====
module s2d_cell (
  input  logic                        clk_i,
  input  s2d_pkg::cell_mode_e         mode_i,
  input  logic                        bit_i,
  input  logic [s2d_pkg::DigitW-1:0]  digit_i,
  output logic                        bit_o,
  output logic [s2d_pkg::DigitW-1:0]  digit_o
);
  import s2d_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] adj;

  // add-3 correction ahead of the shift
  assign adj   = (digit_q >= DabbleLimit) ? digit_q + DabbleAdd : digit_q;
  assign bit_o = adj[DigitW-1];

  always_comb begin
    unique case (mode_i)
      CellClear:  digit_d = '0;
      CellDabble: digit_d = {adj[DigitW-2:0], bit_i};
      CellShift:  digit_d = digit_i;
      default:    digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// ===== tb/sv/signed_binary_to_decimal_text_tb.sv =====
module signed_binary_to_decimal_text_tb;
  import s2d_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start_i = 1'b0;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     busy_o;
  logic                     char_valid_o;
  logic [7:0]               text_char_o;
  logic                     last_char_o;

  logic signed [ValueW-1:0] pending_words[$];
  text_char_t               expected_chars[$];
  int unsigned              idle_left  = 0;
  int unsigned              mismatches = 0;

  signed_binary_to_decimal_text dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decimal text of one word: optional minus, then digits MSD first.
  function automatic void push_decimal_text(input logic signed [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [7:0]        digits [20];
    int                n;
    mag = v[ValueW-1] ? (~v + 64'd1) : v;
    n = 0;
    do begin
      digits[n] = AsciiZero + 8'(mag % 64'd10);
      n++;
      mag = mag / 64'd10;
    end while (mag != 0 && n < 20);
    if (v[ValueW-1]) expected_chars.push_back('{code: AsciiMinus, last: 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      expected_chars.push_back('{code: digits[k], last: (k == 0)});
    end
  endfunction

  function automatic logic signed [ValueW-1:0] random_word();
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] span;
    int                ndigits;
    span = 64'd1;
    ndigits = $urandom_range(1, 19);
    for (int k = 0; k < ndigits; k++) span = span * 64'd10;
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: begin
        // magnitude of a random digit count
        mag = {$urandom, $urandom} % span;
        return $urandom_range(0, 1) ? -mag : mag;
      end
      2: begin
        // close to the extremes and to zero
        case ($urandom_range(0, 2))
          0:       mag = 64'h8000_0000_0000_0000;
          1:       mag = 64'h7fff_ffff_ffff_ffff;
          default: mag = 64'd0;
        endcase
        return mag + 64'($urandom_range(0, 20)) - 64'd10;
      end
      default: begin
        mag = 64'($urandom_range(0, 1000));
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // Driver: holds a word until taken, idles in bursts except near the end.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      value_i   <= '0;
      idle_left <= 0;
    end else begin
      if (start_i && !busy_o) push_decimal_text(value_i);
      if (start_i && busy_o) begin
        // not yet taken
      end else if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start_i   <= 1'b0;
      end else if (pending_words.size() != 0) begin
        if (pending_words.size() > 40 && $urandom_range(0, 2) == 0) begin
          idle_left <= $urandom_range(0, 14);
          start_i   <= 1'b0;
        end else begin
          start_i <= 1'b1;
          value_i <= pending_words.pop_front();
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && char_valid_o) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char: expected none, actual %0d last %b",
                 $time, text_char_o, last_char_o);
      end else begin
        want = expected_chars.pop_front();
        if (text_char_o !== want.code) begin
          mismatches++;
          $display("%0t: text_char mismatch: expected %0d, actual %0d",
                   $time, want.code, text_char_o);
        end
        if (last_char_o !== want.last) begin
          mismatches++;
          $display("%0t: last_char mismatch: expected %b, actual %b",
                   $time, want.last, last_char_o);
        end
      end
    end
  end

  initial begin
    pending_words.push_back(64'sd0);
    pending_words.push_back(64'sd1);
    pending_words.push_back(-64'sd1);
    pending_words.push_back(64'sd9);
    pending_words.push_back(64'sd10);
    pending_words.push_back(-64'sd10);
    pending_words.push_back(-64'sd7);
    pending_words.push_back(64'sd12345);
    pending_words.push_back(64'h7fff_ffff_ffff_ffff);
    pending_words.push_back(64'h8000_0000_0000_0000);
    pending_words.push_back(64'h8000_0000_0000_0001);
    pending_words.push_back(64'h7fff_ffff_ffff_fffe);
    pending_words.push_back(64'sd9223372036854775800);
    pending_words.push_back(-64'sd9223372036854775800);
    pending_words.push_back(64'sd1000000000000000000);
    pending_words.push_back(-64'sd1000000000000000000);
    pending_words.push_back(64'sd999999999999999999);
    pending_words.push_back(64'sd100);
    pending_words.push_back(-64'sd99);
    pending_words.push_back(64'h5555_5555_5555_5555);
    pending_words.push_back(64'haaaa_aaaa_aaaa_aaaa);
    repeat (390) pending_words.push_back(random_word());

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_words.size() != 0 || start_i) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
